// File: rtl/core/centered_window_sum_mean_assert.svh
// assertion macros for the centered window sum and mean block
`ifndef CENTERED_WINDOW_SUM_MEAN_ASSERT_SVH
`define CENTERED_WINDOW_SUM_MEAN_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CWSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CWSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cwsm_pkg.sv
// types and constants shared by the centered window sum and mean block
`timescale 1ns / 1ps

package cwsm_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_W     = 22;
    localparam int RADIUS_W    = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int SEEN_W      = 6;

    localparam logic [SEEN_W-1:0]   SEEN_MAX     = 6'd63;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEAN_MODE = 1'd1;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_last;
    } cwsm_in_t;

    // result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_stream;
    } cwsm_out_t;

    // control part of a window token moving down the cell chain
    typedef struct packed {
        logic valid;
        logic eos;
    } cwsm_tok_t;

    // issue sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } cwsm_state_t;

endpackage

// File: rtl/core/cwsm_cell.sv
// one cell of the window chain: holds one sample and adds it to passing tokens whose window covers it
`timescale 1ns / 1ps

module cwsm_cell
    import cwsm_pkg::*;
#(
    parameter int POS   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 6,
    parameter int SUM_W = 22
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic                          advance,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  cwsm_tok_t                     ctl_in,
    input  logic [IDX_W-1:0]              lo_in,
    input  logic [IDX_W-1:0]              hi_in,
    input  logic [CNT_W-1:0]              cnt_in,
    input  logic signed [SUM_W-1:0]       sum_in,
    output cwsm_tok_t                     ctl_out,
    output logic [IDX_W-1:0]              lo_out,
    output logic [IDX_W-1:0]              hi_out,
    output logic [CNT_W-1:0]              cnt_out,
    output logic signed [SUM_W-1:0]       sum_out
);

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    cwsm_tok_t                     ctl_reg;
    logic [IDX_W-1:0]              lo_reg;
    logic [IDX_W-1:0]              hi_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic                          hit;
    logic signed [SUM_W-1:0]       sum_next;

    // sample line shifts by one place per accepted item
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= sample_in;
        end
    end

    // this sample belongs to the token's window when its position is in range
    assign hit      = ctl_in.valid && (lo_in <= MY_POS) && (hi_in >= MY_POS);
    assign sum_next = hit ? (sum_in + SUM_W'(sample_reg)) : sum_in;

    // token control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // token payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lo_reg  <= lo_in;
            hi_reg  <= hi_in;
            cnt_reg <= cnt_in;
            sum_reg <= sum_next;
        end
    end

    assign sample_out = sample_reg;
    assign ctl_out    = ctl_reg;
    assign lo_out     = lo_reg;
    assign hi_out     = hi_reg;
    assign cnt_out    = cnt_reg;
    assign sum_out    = sum_reg;

endmodule

// File: rtl/core/cwsm_mean.sv
// window mean by reciprocal multiply or the raw window sum, two register stages, mean truncating toward zero
`timescale 1ns / 1ps

module cwsm_mean
    import cwsm_pkg::*;
#(
    parameter int DEPTH = 33,
    parameter int IDX_W = 6,
    parameter int CNT_W = 6,
    parameter int SUM_W = 22
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    mean_mode,
    input  cwsm_tok_t               ctl_in,
    input  logic [CNT_W-1:0]        cnt_in,
    input  logic signed [SUM_W-1:0] sum_in,
    output cwsm_tok_t               ctl_out,
    output cwsm_out_t               res
);

    // magnitude stays below 2^MAG_W since the window depth is odd
    localparam int MAG_W  = SUM_W - 1;
    localparam int K      = MAG_W + IDX_W;
    localparam int M_W    = K + 1;
    localparam int PROD_W = MAG_W + M_W;
    localparam int LUT_N  = 2 ** CNT_W;
    localparam int WIDE   = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;

    logic [M_W-1:0]          recip_lut [0:LUT_N-1];
    logic signed [SUM_W-1:0] abs_full;
    logic                    neg_in;

    cwsm_tok_t               s1_ctl_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic                    s1_neg_reg;
    logic [MAG_W-1:0]        s1_mag_reg;
    logic [M_W-1:0]          s1_m_reg;

    cwsm_tok_t               s2_ctl_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic                    s2_neg_reg;
    logic [PROD_W-1:0]       s2_prod_reg;

    logic [MAG_W-1:0]        quot;
    logic signed [SUM_W-1:0] quot_pos;
    logic signed [SUM_W-1:0] quot_s;
    logic signed [SUM_W-1:0] pick;
    logic signed [WIDE-1:0]  pick_wide;

    // reciprocal table: ceil(2^K / c) for every window count c
    for (genvar c = 0; c < LUT_N; c++)
    begin : g_recip
        localparam longint unsigned CDIV = (c == 0) ? 64'd1 : 64'(c);
        localparam longint unsigned RC   = (c == 0 || c > DEPTH) ? 64'd0 :
            ((64'd1 << K) + CDIV - 64'd1) / CDIV;
        assign recip_lut[c] = M_W'(RC);
    end

    // sign and magnitude of the window sum
    assign neg_in   = sum_in[SUM_W-1];
    assign abs_full = neg_in ? -sum_in : sum_in;

    // control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s1_ctl_reg <= ctl_in;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // stage one: magnitude and reciprocal, stage two: product
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sum_reg  <= sum_in;
            s1_neg_reg  <= neg_in;
            s1_mag_reg  <= abs_full[MAG_W-1:0];
            s1_m_reg    <= recip_lut[cnt_in];
            s2_sum_reg  <= s1_sum_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= PROD_W'(s1_mag_reg) * PROD_W'(s1_m_reg);
        end
    end

    // quotient back to signed, then pick mean or raw sum
    assign quot      = s2_prod_reg[K +: MAG_W];
    assign quot_pos  = $signed({1'b0, quot});
    assign quot_s    = s2_neg_reg ? -quot_pos : quot_pos;
    assign pick      = mean_mode ? quot_s : s2_sum_reg;
    assign pick_wide = WIDE'(pick);

    assign ctl_out           = s2_ctl_reg;
    assign res.value         = pick_wide[VALUE_W-1:0];
    assign res.end_of_stream = s2_ctl_reg.eos;

endmodule

// File: rtl/core/centered_window_sum_mean.sv
// Top level: centered window sum or mean over a stream of signed Q8.8 samples.
// Path: an accepted item puts the sequencer into its issue state; each token it launches passes
//   the 2*MAX_RADIUS+1 cell chain, the two mean stages and the output register.
// Throughput: a new item is taken only while the sequencer is idle and no token is in flight;
//   an item's results leave one per cycle unless stalled.
// Reset clears control state and sets radius 1 and mean mode; sample cells are not cleared.
`timescale 1ns / 1ps
`include "centered_window_sum_mean_assert.svh"

module centered_window_sum_mean
    import cwsm_pkg::*;
#(
    parameter int MAX_RADIUS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  cwsm_in_t               sample_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output cwsm_out_t              result_item,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = (IDX_W > SEEN_W) ? IDX_W : SEEN_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SAMPLE_BITS + IDX_W;

    logic [RADIUS_W-1:0] radius_reg;
    logic                mean_mode_reg;

    cwsm_state_t         state_reg;
    cwsm_state_t         state_next;
    logic [CW-1:0]       pend_reg;
    logic [CW-1:0]       pend_next;
    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   seen_next;
    logic                last_reg;
    logic                last_next;
    logic [CW-1:0]       flight_reg;
    logic [CW-1:0]       flight_next;

    logic                accept;
    logic                advance;
    logic                issue;
    logic                more;
    logic [CW-1:0]       r_sat;
    logic [CW-1:0]       d;
    logic [CW-1:0]       back_avail;
    logic [CW-1:0]       back;
    logic [CW-1:0]       fwd;
    logic [CW-1:0]       lo_full;
    logic [CW-1:0]       hi_full;
    logic [CW-1:0]       cnt_full;

    logic                result_valid_reg;
    cwsm_out_t           result_reg;

    cwsm_tok_t                     ctl_w [0:DEPTH];
    logic [IDX_W-1:0]              lo_w  [0:DEPTH];
    logic [IDX_W-1:0]              hi_w  [0:DEPTH];
    logic [CNT_W-1:0]              cnt_w [0:DEPTH];
    logic signed [SUM_W-1:0]       sum_w [0:DEPTH];
    logic signed [SAMPLE_BITS-1:0] smp_w [0:DEPTH-1];

    cwsm_tok_t                     mean_ctl;
    cwsm_out_t                     mean_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RESET;
            mean_mode_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RADIUS:    radius_reg    <= cfg_data[RADIUS_W-1:0];
                REG_MEAN_MODE: mean_mode_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // radius limited to the chain size
    assign r_sat = (CW'(radius_reg) > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : CW'(radius_reg);

    // handshakes: whole token pipeline moves when the output register can take
    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = (state_reg == ST_IDLE) && (flight_reg == '0);
    assign accept       = sample_valid && sample_ready;

    // window of the oldest pending position
    assign more       = last_reg ? (pend_reg != '0) : (pend_reg > r_sat);
    assign d          = pend_reg - CW'(1);
    assign back_avail = CW'(seen_reg) - CW'(1) - d;
    assign back       = (back_avail < r_sat) ? back_avail : r_sat;
    assign fwd        = last_reg ? ((d < r_sat) ? d : r_sat) : r_sat;
    assign lo_full    = d - fwd;
    assign hi_full    = d + back;
    assign cnt_full   = back + fwd + CW'(1);

    // issue sequencer: next state and token launch
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        seen_next  = seen_reg;
        last_next  = last_reg;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next  = pend_reg + CW'(1);
                    seen_next  = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SEEN_W'(1);
                    last_next  = sample_item.is_last;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (more)
                begin
                    if (advance)
                    begin
                        issue     = 1'b1;
                        pend_next = pend_reg - CW'(1);
                    end
                end
                else
                begin
                    if (last_reg)
                    begin
                        seen_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            seen_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            seen_reg  <= seen_next;
            last_reg  <= last_next;
        end
    end

    // tokens in flight between launch and the output register
    always_comb
    begin
        flight_next = flight_reg;
        if (advance && issue && !mean_ctl.valid)
        begin
            flight_next = flight_reg + CW'(1);
        end
        else if (advance && !issue && mean_ctl.valid)
        begin
            flight_next = flight_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    // token entering the head of the chain
    assign ctl_w[0].valid = issue;
    assign ctl_w[0].eos   = last_reg && (d == '0);
    assign lo_w[0]        = lo_full[IDX_W-1:0];
    assign hi_w[0]        = hi_full[IDX_W-1:0];
    assign cnt_w[0]       = CNT_W'(cnt_full);
    assign sum_w[0]       = '0;

    // chain of cells, cell k holds the sample k places back from the newest
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] smp_feed;
        if (k == 0)
        begin : g_head
            assign smp_feed = sample_item.sample;
        end
        else
        begin : g_body
            assign smp_feed = smp_w[k-1];
        end

        cwsm_cell #(
            .POS   (k),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .advance    (advance),
            .sample_in  (smp_feed),
            .sample_out (smp_w[k]),
            .ctl_in     (ctl_w[k]),
            .lo_in      (lo_w[k]),
            .hi_in      (hi_w[k]),
            .cnt_in     (cnt_w[k]),
            .sum_in     (sum_w[k]),
            .ctl_out    (ctl_w[k+1]),
            .lo_out     (lo_w[k+1]),
            .hi_out     (hi_w[k+1]),
            .cnt_out    (cnt_w[k+1]),
            .sum_out    (sum_w[k+1])
        );
    end

    // mean stages after the chain
    cwsm_mean #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .mean_mode (mean_mode_reg),
        .ctl_in    (ctl_w[DEPTH]),
        .cnt_in    (cnt_w[DEPTH]),
        .sum_in    (sum_w[DEPTH]),
        .ctl_out   (mean_ctl),
        .res       (mean_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= mean_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && mean_ctl.valid)
        begin
            result_reg <= mean_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    // checks on sequencer and token bookkeeping
    `CWSM_ASSERT_NOW(a_no_accept_in_flight, flight_reg != '0, !sample_ready,
        "item accepted while tokens are in flight")
    `CWSM_ASSERT_NOW(a_pend_bound, 1'b1, pend_reg <= CW'(MAX_RADIUS + 1),
        "pending count beyond chain limit")
    `CWSM_ASSERT_NEXT(a_stream_end_clears,
        (state_reg == ST_ISSUE) && !more && last_reg,
        (seen_reg == '0) && (pend_reg == '0),
        "stream end did not clear counters")
    `CWSM_ASSERT_NOW(a_token_counted, mean_ctl.valid, flight_reg != '0,
        "token reached output without being counted")

endmodule
